>>> rtl/core/mst_pkg.sv
// Shared types and constants for the spanning tree engine.
// No dependencies.
package mst_pkg;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] ST_EDGE   = 2'd0;
  localparam logic [1:0] ST_DISCON = 2'd1;
  localparam logic [1:0] ST_SINGLE = 2'd2;

  localparam logic [14:0] TOTAL_MAX = 15'h7fff;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;
    logic [9:0] edge_weight;
  } in_t;

  typedef struct packed {
    logic [4:0]  from_vertex;
    logic [4:0]  to_vertex;
    logic [9:0]  edge_cost;
    logic [14:0] total_cost;
    logic [1:0]  status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic       clr_wr;
    logic [9:0] clr_addr;
    logic       latch;
    logic       wr_ab;
    logic       wr_ba;
    logic       init;
    logic       rd_en;
    logic [4:0] rd_j;
    logic       proc;
    logic [4:0] proc_j;
    logic       emit;
    logic       single;
    logic       last_edge;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/mst_ctrl.sv
// Sequencer for clear, edge write and Prim runs.
// Depends on mst_pkg.
module mst_ctrl #(
  parameter int MAX_VERTICES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    op_i,
  output logic          in_ready_o,
  input  logic          cfg_we_i,
  input  logic [5:0]    cfg_data_i,
  input  mst_pkg::sts_t sts_i,
  output mst_pkg::cmd_t cmd_o
);

  localparam int IDX_LIM = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int VW = (IDX_LIM > 1) ? $clog2(IDX_LIM) : 1;
  localparam logic [9:0] CLR_LAST = 10'((2 ** (2 * VW)) - 1);
  localparam logic [5:0] BOUND = 6'(IDX_LIM);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WR_AB, S_WR_BA, S_START, S_SCAN, S_DRAIN, S_EMIT
  } state_e;

  state_e     state_q;
  logic [9:0] cnt_q;
  logic [4:0] j_q, pj_q;
  logic       proc_q, single_q;
  logic [5:0] step_q, vcount_q, n;
  logic       accept, emit, last_edge;

  always_comb begin
    n = vcount_q;
    if (n == 6'd0) n = 6'd1;
    if (n > BOUND) n = BOUND;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q == S_EMIT) && sts_i.out_free;
  assign last_edge  = (step_q + 6'd2) == n;

  always_comb begin
    cmd_o           = '0;
    cmd_o.clr_wr    = (state_q == S_CLEAR);
    cmd_o.clr_addr  = cnt_q;
    cmd_o.latch     = accept;
    cmd_o.wr_ab     = (state_q == S_WR_AB);
    cmd_o.wr_ba     = (state_q == S_WR_BA);
    cmd_o.init      = (state_q == S_START);
    cmd_o.rd_en     = (state_q == S_SCAN);
    cmd_o.rd_j      = j_q;
    cmd_o.proc      = proc_q;
    cmd_o.proc_j    = pj_q;
    cmd_o.emit      = emit;
    cmd_o.single    = single_q;
    cmd_o.last_edge = last_edge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      j_q      <= '0;
      pj_q     <= '0;
      proc_q   <= 1'b0;
      single_q <= 1'b0;
      step_q   <= '0;
      vcount_q <= 6'd32;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_data_i;
      proc_q <= (state_q == S_SCAN);
      pj_q   <= j_q;
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 10'd1;
          if (cnt_q == CLR_LAST) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (op_i)
              mst_pkg::OP_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_CLEAR;
              end
              mst_pkg::OP_ADD:     state_q <= S_WR_AB;
              mst_pkg::OP_COMPUTE: state_q <= S_START;
              default:             state_q <= S_IDLE;
            endcase
          end
        end
        S_WR_AB: state_q <= S_WR_BA;
        S_WR_BA: state_q <= S_IDLE;
        S_START: begin
          step_q   <= '0;
          j_q      <= '0;
          single_q <= (n == 6'd1);
          state_q  <= (n == 6'd1) ? S_EMIT : S_SCAN;
        end
        S_SCAN: begin
          if (6'(j_q) == n - 6'd1) state_q <= S_DRAIN;
          else j_q <= j_q + 5'd1;
        end
        S_DRAIN: state_q <= S_EMIT;
        S_EMIT: begin
          if (emit) begin
            if (single_q || !sts_i.found || last_edge) begin
              state_q <= S_IDLE;
            end else begin
              step_q  <= step_q + 6'd1;
              j_q     <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/mst_datapath.sv
// Matrix memory, key/parent table, best-edge compare and result register.
// Depends on mst_pkg.
module mst_datapath #(
  parameter int MAX_VERTICES = 32,
  parameter int NO_EDGE_COST = 999
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mst_pkg::in_t  in_data_i,
  input  mst_pkg::cmd_t cmd_i,
  output mst_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mst_pkg::out_t out_data_o
);

  localparam int IDX_LIM = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int VW = (IDX_LIM > 1) ? $clog2(IDX_LIM) : 1;
  localparam int NV = 2 ** VW;
  localparam int AW = 2 * VW;
  localparam logic [16:0] NEC = 17'(NO_EDGE_COST);

  logic [9:0]    mem [2 ** AW];
  logic [9:0]    rd_q;
  logic [4:0]    a_q, b_q;
  logic [9:0]    w_q;
  logic          range_ok_q;
  logic [VW-1:0] v_q;
  logic [9:0]    key_q [NV];
  logic [VW-1:0] par_q [NV];
  logic [NV-1:0] kv_q, vis_q;
  logic [9:0]    bk_q;
  logic [VW-1:0] bp_q, bj_q;
  logic          bv_q;
  logic [14:0]   total_q;
  logic          out_valid_q;
  mst_pkg::out_t out_q, res;

  logic [VW-1:0] pj;
  logic          edge_ok, upd, cv, better;
  logic [9:0]    ck;
  logic [VW-1:0] cp;
  logic [15:0]   sum;
  logic [14:0]   sat;

  assign pj      = cmd_i.proc_j[VW-1:0];
  assign edge_ok = (rd_q != 10'd0) && (17'(rd_q) < NEC);
  assign upd     = cmd_i.proc && !vis_q[pj] && edge_ok &&
                   (!kv_q[pj] || rd_q < key_q[pj] ||
                    (rd_q == key_q[pj] && v_q < par_q[pj]));
  assign ck      = upd ? rd_q : key_q[pj];
  assign cp      = upd ? v_q : par_q[pj];
  assign cv      = cmd_i.proc && !vis_q[pj] && (kv_q[pj] || upd);
  assign better  = cv && (!bv_q || ck < bk_q || (ck == bk_q && cp < bp_q));

  assign sum = {1'b0, total_q} + 16'(bk_q);
  assign sat = sum[15] ? mst_pkg::TOTAL_MAX : sum[14:0];

  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (cmd_i.single) begin
      res.status = mst_pkg::ST_SINGLE;
    end else if (!bv_q) begin
      res.status     = mst_pkg::ST_DISCON;
      res.total_cost = total_q;
    end else begin
      res.status      = mst_pkg::ST_EDGE;
      res.from_vertex = 5'(bp_q);
      res.to_vertex   = 5'(bj_q);
      res.edge_cost   = bk_q;
      res.total_cost  = sat;
      res.last        = cmd_i.last_edge;
    end
  end

  assign sts_o.found    = bv_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[cmd_i.clr_addr[AW-1:0]] <= '0;
    end else if (cmd_i.wr_ab && range_ok_q) begin
      mem[{a_q[VW-1:0], b_q[VW-1:0]}] <= w_q;
    end else if (cmd_i.wr_ba && range_ok_q) begin
      mem[{b_q[VW-1:0], a_q[VW-1:0]}] <= w_q;
    end
    if (cmd_i.rd_en) rd_q <= mem[{v_q, cmd_i.rd_j[VW-1:0]}];
    if (cmd_i.latch) begin
      a_q        <= in_data_i.vertex_a;
      b_q        <= in_data_i.vertex_b;
      w_q        <= in_data_i.edge_weight;
      range_ok_q <= (32'(in_data_i.vertex_a) < MAX_VERTICES) &&
                    (32'(in_data_i.vertex_b) < MAX_VERTICES);
    end
    if (upd) begin
      key_q[pj] <= rd_q;
      par_q[pj] <= v_q;
    end
    if (better) begin
      bk_q <= ck;
      bp_q <= cp;
      bj_q <= pj;
    end
    if (cmd_i.emit) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kv_q        <= '0;
      vis_q       <= '0;
      bv_q        <= 1'b0;
      v_q         <= '0;
      total_q     <= '0;
    end else begin
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.init) begin
        kv_q    <= '0;
        vis_q   <= NV'(1);
        bv_q    <= 1'b0;
        v_q     <= '0;
        total_q <= '0;
      end else if (cmd_i.emit) begin
        bv_q <= 1'b0;
        if (bv_q && !cmd_i.single) begin
          vis_q[bj_q] <= 1'b1;
          total_q     <= sat;
          v_q         <= bj_q;
        end
      end else begin
        if (upd) kv_q[pj] <= 1'b1;
        if (better) bv_q <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/prim_mst_adjacency_matrix.sv
// Top level of the Prim spanning tree engine over an adjacency matrix.
// Depends on mst_pkg, mst_ctrl and mst_datapath.
//
// One item at a time. After reset and on every clear item the matrix memory is
// swept one entry a cycle (1024 entries at 32 vertices) while no item is taken.
// An edge write latches the item, then writes the a-to-b entry and then the
// b-to-a entry. In a compute run over n vertices, each new tree vertex costs one
// scan of its matrix row through the single registered read port, folded into
// a per-vertex best-key table. Results leave through an output register.
module prim_mst_adjacency_matrix #(
  parameter int MAX_VERTICES = 32,
  parameter int NO_EDGE_COST = 999
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mst_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mst_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [5:0]    cfg_data_i
);

  mst_pkg::cmd_t cmd;
  mst_pkg::sts_t sts;

  mst_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.op),
    .in_ready_o (in_ready_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mst_datapath #(
    .MAX_VERTICES(MAX_VERTICES),
    .NO_EDGE_COST(NO_EDGE_COST)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over a waiting beat");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != mst_pkg::ST_EDGE) |-> out_data_o.last)
    else $error("terminal status without last");

  a_no_accept_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !cmd.emit && !cmd.rd_en)
    else $error("input accepted during a run");

endmodule
